// ===== rtl/mwe_pkg.sv =====
// ============================================================================
// mwe_pkg: shared types and constants for the Microwire EEPROM read master
// Holds default parameter values, register reset values, register indexes
// and the configuration bundle handed from the top level to the engine.
// ============================================================================
package mwe_pkg;

  // Default sizes of the serial frame.
  localparam int DATA_BITS_DEF        = 16;
  localparam int OPCODE_BITS_DEF      = 3;
  localparam int MAX_ADDRESS_BITS_DEF = 8;

  // Fixed field widths.
  localparam int WORD_BITS    = 16;
  localparam int ADDR_IN_BITS = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  // Read opcode, right aligned; the low OPCODE_BITS bits are sent.
  localparam logic [3:0] READ_OPCODE = 4'h6;

  // Address length of the small part.
  localparam int SMALL_ADDRESS_BITS = 6;

  // Register reset values.
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
  localparam logic [7:0]  POLL_TICKS_RESET  = 8'd5;
  localparam logic [15:0] POLL_LIMIT_RESET  = 16'd1000;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HALF_PERIOD = 2'd0,
    REG_POLL_TICKS  = 2'd1,
    REG_POLL_LIMIT  = 2'd2,
    REG_LARGE_PART  = 2'd3
  } cfg_index_t;

  // Configuration registers as seen by the engine.
  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [7:0]  grant_poll_ticks;
    logic [15:0] grant_poll_limit;
    logic        large_part;
  } cfg_t;

endpackage

// ===== rtl/microwire_eeprom_read_master.sv =====
// ============================================================================
// microwire_eeprom_read_master: Microwire EEPROM word-read master
// Steps a Microwire read sequence once per accepted timer tick and returns
// the pin levels and completion status that the tick produces.
// ============================================================================
//
//   Channel   Direction  Handshake               Contents
//   --------  ---------  ----------------------  ------------------------------
//   input     in         in_valid / in_ready     one timer tick with start,
//                                                address, grant and data pin
//   output    out        out_valid / out_ready   pin levels, busy, done, error
//                                                and the word read
//   config    in         cfg_write               register index and data
//
// Each tick transaction is handled on the edge that accepts it: the engine
// updates its state and the result register there, so one tick per cycle
// is sustained while the output side keeps up.
// A result waits in the output register; a new tick is accepted in the same
// cycle that the waiting result is taken, and only a stalled, full output
// register holds off the input.
// Reset is synchronous and returns the sequencer to idle with all pins low
// and the registers at their reset values.
//
module microwire_eeprom_read_master #(
  parameter int DATA_BITS        = mwe_pkg::DATA_BITS_DEF,
  parameter int OPCODE_BITS      = mwe_pkg::OPCODE_BITS_DEF,
  parameter int MAX_ADDRESS_BITS = mwe_pkg::MAX_ADDRESS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_write,
  input  logic [mwe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mwe_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Tick input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                start_req,
  input  logic [mwe_pkg::ADDR_IN_BITS-1:0]    word_address,
  input  logic                                grant_in,
  input  logic                                serial_in,
  // Result output channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                clock_out,
  output logic                                select_out,
  output logic                                serial_out,
  output logic                                request_out,
  output logic                                busy_res,
  output logic                                done_res,
  output logic                                grant_error,
  output logic [mwe_pkg::WORD_BITS-1:0]       read_word
);

  mwe_pkg::cfg_t cfg;
  logic          in_accept;

  // The output register is free when empty or when its result leaves now.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Configuration registers. Writes must arrive only while no transaction
  // is in flight; the block does not enforce it. Mid-read changes apply at
  // the next timer load; the address length is already fixed in the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= mwe_pkg::HALF_PERIOD_RESET;
      cfg.grant_poll_ticks  <= mwe_pkg::POLL_TICKS_RESET;
      cfg.grant_poll_limit  <= mwe_pkg::POLL_LIMIT_RESET;
      cfg.large_part        <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        mwe_pkg::REG_HALF_PERIOD: cfg.half_period_ticks <= cfg_data;
        mwe_pkg::REG_POLL_TICKS:  cfg.grant_poll_ticks  <= cfg_data[7:0];
        mwe_pkg::REG_POLL_LIMIT:  cfg.grant_poll_limit  <= cfg_data;
        mwe_pkg::REG_LARGE_PART:  cfg.large_part        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Output valid flag: set by every accepted tick, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The engine's pin and status registers double as the result register;
  // they change only on an accepted tick and so hold while the output stalls.
  mwe_engine #(
    .DATA_BITS        (DATA_BITS),
    .OPCODE_BITS      (OPCODE_BITS),
    .MAX_ADDRESS_BITS (MAX_ADDRESS_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .advance      (in_accept),
    .cfg          (cfg),
    .start_req    (start_req),
    .word_address (word_address),
    .grant_in     (grant_in),
    .serial_in    (serial_in),
    .clock_out    (clock_out),
    .select_out   (select_out),
    .serial_out   (serial_out),
    .request_out  (request_out),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .grant_error  (grant_error),
    .read_word    (read_word)
  );

endmodule

// ===== rtl/mwe_engine.sv =====
// ============================================================================
// mwe_engine: per-tick sequencer of the Microwire read master
// Advances the pin-level state machine by one timer tick whenever advance
// is high and registers the pin levels and the completion status.
// ============================================================================
module mwe_engine #(
  parameter int DATA_BITS        = mwe_pkg::DATA_BITS_DEF,
  parameter int OPCODE_BITS      = mwe_pkg::OPCODE_BITS_DEF,
  parameter int MAX_ADDRESS_BITS = mwe_pkg::MAX_ADDRESS_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 advance,
  input  mwe_pkg::cfg_t                        cfg,
  input  logic                                 start_req,
  input  logic [mwe_pkg::ADDR_IN_BITS-1:0]     word_address,
  input  logic                                 grant_in,
  input  logic                                 serial_in,
  output logic                                 clock_out,
  output logic                                 select_out,
  output logic                                 serial_out,
  output logic                                 request_out,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic                                 grant_error,
  output logic [mwe_pkg::WORD_BITS-1:0]        read_word
);

  localparam int CMD_BITS   = OPCODE_BITS + MAX_ADDRESS_BITS;
  localparam int CMD_IDX_W  = $clog2(CMD_BITS);
  localparam int BC_MAX     = (CMD_BITS > DATA_BITS) ? CMD_BITS : DATA_BITS;
  localparam int BC_W       = $clog2(BC_MAX + 1);
  localparam int ADDR_EXT_W = (MAX_ADDRESS_BITS > mwe_pkg::ADDR_IN_BITS) ?
                              MAX_ADDRESS_BITS : mwe_pkg::ADDR_IN_BITS;

  typedef enum logic [3:0] {
    PH_IDLE, PH_GRANT, PH_OUT_SETUP, PH_OUT_HIGH, PH_OUT_LOW,
    PH_IN_HIGH, PH_IN_LOW, PH_REL_HIGH, PH_REL_LOW
  } phase_t;

  phase_t                       phase, phase_next;
  logic [15:0]                  tick_timer, tick_timer_next;
  logic [15:0]                  poll_count, poll_count_next;
  logic [BC_W-1:0]              bit_count, bit_count_next;
  logic [CMD_BITS-1:0]          command_shift, command_shift_next;
  logic [mwe_pkg::WORD_BITS-1:0] read_shift, read_shift_next;
  logic                         clk_pin, clk_pin_next;
  logic                         cs_pin, cs_pin_next;
  logic                         di_pin, di_pin_next;
  logic                         req_pin, req_pin_next;
  logic                         done_next, error_next;
  logic [mwe_pkg::WORD_BITS-1:0] word_next;

  logic [15:0]                  half_load, poll_load;
  logic [BC_W-1:0]              bc_dec;
  logic                         next_cmd_bit;
  logic [ADDR_EXT_W-1:0]        addr_ext;
  logic [OPCODE_BITS-1:0]       opcode;

  // A zero interval behaves as one tick.
  assign half_load = (cfg.half_period_ticks == 16'd0) ? 16'd0 :
                     cfg.half_period_ticks - 16'd1;
  assign poll_load = (cfg.grant_poll_ticks == 8'd0) ? 16'd0 :
                     {8'd0, cfg.grant_poll_ticks - 8'd1};

  assign bc_dec       = bit_count - BC_W'(1);
  assign next_cmd_bit = command_shift[bc_dec[CMD_IDX_W-1:0]];
  assign addr_ext     = ADDR_EXT_W'(word_address);
  assign opcode       = mwe_pkg::READ_OPCODE[OPCODE_BITS-1:0];

  always_comb begin
    phase_next         = phase;
    tick_timer_next    = tick_timer;
    poll_count_next    = poll_count;
    bit_count_next     = bit_count;
    command_shift_next = command_shift;
    read_shift_next    = read_shift;
    clk_pin_next       = clk_pin;
    cs_pin_next        = cs_pin;
    di_pin_next        = di_pin;
    req_pin_next       = req_pin;
    done_next          = 1'b0;
    error_next         = 1'b0;
    word_next          = '0;

    if (phase == PH_IDLE) begin
      if (start_req) begin
        if (cfg.large_part) begin
          command_shift_next = {opcode, addr_ext[MAX_ADDRESS_BITS-1:0]};
          bit_count_next     = BC_W'(CMD_BITS);
        end else begin
          command_shift_next = CMD_BITS'({opcode,
                                          word_address[mwe_pkg::SMALL_ADDRESS_BITS-1:0]});
          bit_count_next     = BC_W'(OPCODE_BITS + mwe_pkg::SMALL_ADDRESS_BITS);
        end
        poll_count_next = '0;
        tick_timer_next = '0;
        read_shift_next = '0;
        clk_pin_next    = 1'b0;
        cs_pin_next     = 1'b0;
        di_pin_next     = 1'b0;
        req_pin_next    = 1'b1;
        phase_next      = PH_GRANT;
      end
    end else if (tick_timer != 16'd0) begin
      tick_timer_next = tick_timer - 16'd1;
    end else begin
      case (phase)
        PH_GRANT: begin
          if (grant_in) begin
            cs_pin_next     = 1'b1;
            clk_pin_next    = 1'b0;
            di_pin_next     = next_cmd_bit;
            bit_count_next  = bc_dec;
            phase_next      = PH_OUT_SETUP;
            tick_timer_next = half_load;
          end else if (poll_count >= cfg.grant_poll_limit) begin
            clk_pin_next = 1'b0;
            cs_pin_next  = 1'b0;
            di_pin_next  = 1'b0;
            req_pin_next = 1'b0;
            phase_next   = PH_IDLE;
            done_next    = 1'b1;
            error_next   = 1'b1;
          end else begin
            poll_count_next = poll_count + 16'd1;
            tick_timer_next = poll_load;
          end
        end
        PH_OUT_SETUP: begin
          clk_pin_next    = 1'b1;
          phase_next      = PH_OUT_HIGH;
          tick_timer_next = half_load;
        end
        PH_OUT_HIGH: begin
          clk_pin_next    = 1'b0;
          phase_next      = PH_OUT_LOW;
          tick_timer_next = half_load;
        end
        PH_OUT_LOW: begin
          if (bit_count != '0) begin
            di_pin_next    = next_cmd_bit;
            bit_count_next = bc_dec;
            phase_next     = PH_OUT_SETUP;
          end else begin
            di_pin_next    = 1'b0;
            clk_pin_next   = 1'b1;
            bit_count_next = BC_W'(DATA_BITS);
            phase_next     = PH_IN_HIGH;
          end
          tick_timer_next = half_load;
        end
        PH_IN_HIGH: begin
          read_shift_next = {read_shift[mwe_pkg::WORD_BITS-2:0], serial_in};
          bit_count_next  = bc_dec;
          clk_pin_next    = 1'b0;
          phase_next      = PH_IN_LOW;
          tick_timer_next = half_load;
        end
        PH_IN_LOW: begin
          if (bit_count != '0) begin
            clk_pin_next = 1'b1;
            phase_next   = PH_IN_HIGH;
          end else begin
            clk_pin_next = 1'b1;
            cs_pin_next  = 1'b0;
            di_pin_next  = 1'b0;
            req_pin_next = 1'b1;
            phase_next   = PH_REL_HIGH;
          end
          tick_timer_next = half_load;
        end
        PH_REL_HIGH: begin
          clk_pin_next    = 1'b0;
          phase_next      = PH_REL_LOW;
          tick_timer_next = half_load;
        end
        default: begin
          clk_pin_next = 1'b0;
          cs_pin_next  = 1'b0;
          di_pin_next  = 1'b0;
          req_pin_next = 1'b0;
          phase_next   = PH_IDLE;
          done_next    = 1'b1;
          word_next    = read_shift;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_timer    <= '0;
      poll_count    <= '0;
      bit_count     <= '0;
      command_shift <= '0;
      read_shift    <= '0;
      clk_pin       <= 1'b0;
      cs_pin        <= 1'b0;
      di_pin        <= 1'b0;
      req_pin       <= 1'b0;
      done_res      <= 1'b0;
      grant_error   <= 1'b0;
      read_word     <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      tick_timer    <= tick_timer_next;
      poll_count    <= poll_count_next;
      bit_count     <= bit_count_next;
      command_shift <= command_shift_next;
      read_shift    <= read_shift_next;
      clk_pin       <= clk_pin_next;
      cs_pin        <= cs_pin_next;
      di_pin        <= di_pin_next;
      req_pin       <= req_pin_next;
      done_res      <= done_next;
      grant_error   <= error_next;
      read_word     <= word_next;
    end
  end

  assign clock_out   = clk_pin;
  assign select_out  = cs_pin;
  assign serial_out  = di_pin;
  assign request_out = req_pin;
  assign busy_res    = (phase != PH_IDLE);

endmodule

// ===== rtl/mwe_checker.sv =====
// ============================================================================
// mwe_checker: port-level checks for the Microwire EEPROM read master
// Watches the top-level ports over time and is bound to every instance.
// ============================================================================
module mwe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          select_out,
  input logic                          request_out,
  input logic                          busy_res,
  input logic                          done_res,
  input logic                          grant_error,
  input logic [mwe_pkg::WORD_BITS-1:0] read_word
);

  // An accepted tick always leaves a result behind it.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted tick produced no result");

  // An empty output register never holds off the input.
  a_empty_is_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // Chip select is only raised while access is held.
  a_select_needs_request: assert property (@(posedge clk) disable iff (rst)
    (out_valid && select_out) |-> (request_out && busy_res))
    else $error("chip select without access request");

  // A finished read leaves the sequencer idle.
  a_done_is_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (done_res || grant_error)) |-> (done_res && !busy_res))
    else $error("completion status outside an idle result");

  // A word is only reported on successful completion.
  a_word_on_success: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (read_word != '0)) |-> (done_res && !grant_error))
    else $error("read word outside a successful completion");

endmodule

bind microwire_eeprom_read_master mwe_checker u_checker (.*);

// ===== tb/sv/microwire_eeprom_read_master_test.sv =====
// ============================================================================
// microwire_eeprom_read_master_test: self-checking bench for the read master
// A short scripted sequence covers reset behavior, start while busy, grant
// timeouts, zero intervals, a zero poll limit and the address-length latch.
// Random phases with changing register settings then run complete reads
// against a cycle-accurate model of the sequencer, with bursty input
// traffic and a stalling result consumer.
// ============================================================================
module microwire_eeprom_read_master_test;

  // Length of the command frame: opcode followed by the widest address.
  localparam int CMD_W = mwe_pkg::OPCODE_BITS_DEF + mwe_pkg::MAX_ADDRESS_BITS_DEF;

  // After the last result the bench waits SETTLE_CYCLES before touching
  // the registers again.
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_PRINTED   = 60;

  localparam int SCRIPT_LEN   = 24;
  localparam int NUM_PHASES   = 11;
  localparam int PHASE_ITEMS  = 120;
  // The last phase runs the slowest settings; its ticks mostly count down
  // the widest timer loads.
  localparam int SLOW_ITEMS   = 100;
  localparam int HOLD_PHASE   = 4;

  // One timer tick as offered on the input channel.
  typedef struct packed {
    logic       start_req;
    logic [7:0] word_address;
    logic       grant_in;
    logic       serial_in;
  } tick_t;

  // Pin levels and status that one tick produces.
  typedef struct packed {
    logic        clock_out;
    logic        select_out;
    logic        serial_out;
    logic        request_out;
    logic        busy_res;
    logic        done_res;
    logic        grant_error;
    logic [15:0] read_word;
  } tick_result_t;

  // One line of the scripted sequence: either a register write or a tick,
  // optionally with the result written out by hand.
  typedef struct packed {
    logic                  is_write;
    mwe_pkg::cfg_index_t   reg_index;
    logic [15:0]           reg_value;
    tick_t                 tick;
    logic                  typed;
    tick_result_t          result;
  } script_row_t;

  // Sequencer phases of the model.
  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_GRANT, SEQ_OUT_SETUP, SEQ_OUT_HIGH, SEQ_OUT_LOW,
    SEQ_IN_HIGH, SEQ_IN_LOW, SEQ_REL_HIGH, SEQ_REL_LOW
  } seq_phase_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [mwe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mwe_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        start_req = 1'b0;
  logic [mwe_pkg::ADDR_IN_BITS-1:0] word_address = '0;
  logic        grant_in = 1'b0;
  logic        serial_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        clock_out;
  logic        select_out;
  logic        serial_out;
  logic        request_out;
  logic        busy_res;
  logic        done_res;
  logic        grant_error;
  logic [mwe_pkg::WORD_BITS-1:0] read_word;

  // Model state: register copies and the sequencer itself.
  mwe_pkg::cfg_t    cfg_model;
  seq_phase_t       seq;
  logic [15:0]      wait_left;
  logic [15:0]      polls;
  logic [4:0]       bits_left;
  logic [CMD_W-1:0] cmd_bits;
  logic [15:0]      shift_in;
  logic             wide;
  logic             pin_clk, pin_cs, pin_di, pin_req;

  // Results the model has produced that the block has not delivered yet.
  tick_result_t pending_levels[$];

  int  error_count   = 0;
  int  results_seen  = 0;
  int  cycle_count   = 0;
  int  burst_left    = 1;
  int  gap_left      = 0;
  bit  hold_request  = 1'b0;

  script_row_t script [SCRIPT_LEN];

  microwire_eeprom_read_master i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_req   (start_req),
    .word_address(word_address),
    .grant_in    (grant_in),
    .serial_in   (serial_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .clock_out   (clock_out),
    .select_out  (select_out),
    .serial_out  (serial_out),
    .request_out (request_out),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .grant_error (grant_error),
    .read_word   (read_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the sequencer
  // --------------------------------------------------------------------------

  // A timer load of n waits n ticks in total; zero behaves like one.
  function automatic logic [15:0] timer_load(logic [15:0] n);
    return (n == 16'd0) ? 16'd0 : n - 16'd1;
  endfunction

  // Puts the next command bit on the data pin and starts its setup wait.
  function automatic void shift_out_next();
    bits_left = bits_left - 5'd1;
    pin_di    = cmd_bits[bits_left];
    seq       = SEQ_OUT_SETUP;
    wait_left = timer_load(cfg_model.half_period_ticks);
  endfunction

  // Advances the model by one tick and returns the levels it leaves behind.
  function automatic tick_result_t step_sequencer(tick_t t);
    tick_result_t r;
    int           abits;
    r = '0;
    if (seq == SEQ_IDLE) begin
      if (t.start_req) begin
        // The address length is fixed for the whole read at this point.
        wide  = cfg_model.large_part;
        abits = wide ? mwe_pkg::MAX_ADDRESS_BITS_DEF : mwe_pkg::SMALL_ADDRESS_BITS;
        cmd_bits = (CMD_W'(mwe_pkg::READ_OPCODE[mwe_pkg::OPCODE_BITS_DEF-1:0]) << abits)
                 | (CMD_W'(t.word_address) & ((CMD_W'(1) << abits) - CMD_W'(1)));
        bits_left = 5'(mwe_pkg::OPCODE_BITS_DEF + abits);
        polls     = '0;
        wait_left = '0;
        shift_in  = '0;
        {pin_req, pin_cs, pin_di, pin_clk} = 4'b1000;
        seq = SEQ_GRANT;
      end
    end else if (wait_left != 16'd0) begin
      wait_left = wait_left - 16'd1;
    end else begin
      case (seq)
        SEQ_GRANT: begin
          if (t.grant_in) begin
            {pin_req, pin_cs, pin_di, pin_clk} = 4'b1100;
            shift_out_next();
          end else if (polls >= cfg_model.grant_poll_limit) begin
            // Out of polls: release the request and flag the timeout.
            {pin_req, pin_cs, pin_di, pin_clk} = 4'b0000;
            seq = SEQ_IDLE;
            r.done_res    = 1'b1;
            r.grant_error = 1'b1;
          end else begin
            polls     = polls + 16'd1;
            wait_left = timer_load({8'd0, cfg_model.grant_poll_ticks});
          end
        end
        SEQ_OUT_SETUP: begin
          pin_clk   = 1'b1;
          seq       = SEQ_OUT_HIGH;
          wait_left = timer_load(cfg_model.half_period_ticks);
        end
        SEQ_OUT_HIGH: begin
          pin_clk   = 1'b0;
          seq       = SEQ_OUT_LOW;
          wait_left = timer_load(cfg_model.half_period_ticks);
        end
        SEQ_OUT_LOW: begin
          if (bits_left != 5'd0) begin
            shift_out_next();
          end else begin
            pin_di    = 1'b0;
            pin_clk   = 1'b1;
            bits_left = 5'(mwe_pkg::DATA_BITS_DEF);
            seq       = SEQ_IN_HIGH;
            wait_left = timer_load(cfg_model.half_period_ticks);
          end
        end
        SEQ_IN_HIGH: begin
          shift_in  = {shift_in[mwe_pkg::WORD_BITS-2:0], t.serial_in};
          bits_left = bits_left - 5'd1;
          pin_clk   = 1'b0;
          seq       = SEQ_IN_LOW;
          wait_left = timer_load(cfg_model.half_period_ticks);
        end
        SEQ_IN_LOW: begin
          if (bits_left != 5'd0) begin
            pin_clk = 1'b1;
            seq     = SEQ_IN_HIGH;
          end else begin
            // Deselect and give the trailing clock pulse.
            {pin_req, pin_cs, pin_di, pin_clk} = 4'b1001;
            seq = SEQ_REL_HIGH;
          end
          wait_left = timer_load(cfg_model.half_period_ticks);
        end
        SEQ_REL_HIGH: begin
          pin_clk   = 1'b0;
          seq       = SEQ_REL_LOW;
          wait_left = timer_load(cfg_model.half_period_ticks);
        end
        default: begin
          {pin_req, pin_cs, pin_di, pin_clk} = 4'b0000;
          seq         = SEQ_IDLE;
          r.done_res  = 1'b1;
          r.read_word = shift_in;
        end
      endcase
    end
    r.clock_out   = pin_clk;
    r.select_out  = pin_cs;
    r.serial_out  = pin_di;
    r.request_out = pin_req;
    r.busy_res    = (seq != SEQ_IDLE);
    return r;
  endfunction

  function automatic void apply_register(mwe_pkg::cfg_index_t idx, logic [15:0] value);
    case (idx)
      mwe_pkg::REG_HALF_PERIOD: cfg_model.half_period_ticks = value;
      mwe_pkg::REG_POLL_TICKS:  cfg_model.grant_poll_ticks  = value[7:0];
      mwe_pkg::REG_POLL_LIMIT:  cfg_model.grant_poll_limit  = value;
      default:                  cfg_model.large_part        = value[0];
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Script helpers
  // --------------------------------------------------------------------------

  function automatic tick_result_t levels(logic c, logic s, logic d, logic q,
                                          logic b, logic dn, logic e,
                                          logic [15:0] w);
    return '{c, s, d, q, b, dn, e, w};
  endfunction

  function automatic script_row_t tick_row(logic st, logic [7:0] addr, logic g,
                                           logic sd, logic typed,
                                           tick_result_t res);
    script_row_t row;
    row          = '0;
    row.tick     = '{st, addr, g, sd};
    row.typed    = typed;
    row.result   = res;
    return row;
  endfunction

  function automatic script_row_t reg_row(mwe_pkg::cfg_index_t idx, logic [15:0] value);
    script_row_t row;
    row           = '0;
    row.is_write  = 1'b1;
    row.reg_index = idx;
    row.reg_value = value;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Random tick shaped by where the model stands: mostly starts while idle,
  // grants that come after a few polls, and a share of plain noise.
  function automatic tick_t next_random_tick();
    tick_t t;
    t.word_address = 8'($urandom);
    t.serial_in    = 1'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      t.start_req = 1'($urandom);
      t.grant_in  = 1'($urandom);
    end else if (seq == SEQ_IDLE) begin
      t.start_req = ($urandom_range(0, 3) != 0);
      t.grant_in  = ($urandom_range(0, 2) == 0);
    end else begin
      t.start_req = 1'($urandom);
      t.grant_in  = ($urandom_range(0, 4) < 2);
    end
    return t;
  endfunction

  // Offers one tick transaction and waits for it to be taken. The sender
  // works in bursts; between bursts valid drops for a random gap.
  task automatic send_tick(tick_t t, logic typed, tick_result_t typed_res);
    tick_result_t predicted;
    if (gap_left > 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    in_valid     <= 1'b1;
    start_req    <= t.start_req;
    word_address <= t.word_address;
    grant_in     <= t.grant_in;
    serial_in    <= t.serial_in;
    do @(posedge clk); while (!in_ready);
    predicted = step_sequencer(t);
    pending_levels.push_back(typed ? typed_res : predicted);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
  endtask

  // Stops offering ticks and waits until every expected result is out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the task then waits with the write enable low so that it
  // is never lowered and raised in the same step.
  task automatic write_register(mwe_pkg::cfg_index_t idx, logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    apply_register(idx, value);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_error(string msg);
    if (error_count < MAX_PRINTED) $display("error: %s", msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s of result %0d is %0h, expected %0h",
                             name, results_seen, got, want));
  endtask

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected",
                               results_seen));
      end else begin
        want = pending_levels.pop_front();
        check_field("clock_out",   16'(clock_out),   16'(want.clock_out));
        check_field("select_out",  16'(select_out),  16'(want.select_out));
        check_field("serial_out",  16'(serial_out),  16'(want.serial_out));
        check_field("request_out", 16'(request_out), 16'(want.request_out));
        check_field("busy_res",    16'(busy_res),    16'(want.busy_res));
        check_field("done_res",    16'(done_res),    16'(want.done_res));
        check_field("grant_error", 16'(grant_error), 16'(want.grant_error));
        check_field("read_word",   read_word,        want.read_word);
      end
      results_seen++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result consumer
  // --------------------------------------------------------------------------

  // The consumer switches between stall patterns in stretches of random
  // length. When asked, it holds off completely for a long stretch so that
  // the output register fills and the block stops taking ticks.
  initial begin
    int mode, span, step_no, period;
    forever begin
      if (hold_request) begin
        for (step_no = 0; step_no < LONG_HOLD; step_no++) begin
          @(posedge clk);
          out_ready <= 1'b0;
        end
        hold_request = 1'b0;
      end else begin
        mode   = $urandom_range(0, 3);
        span   = $urandom_range(20, 200);
        period = $urandom_range(2, 4);
        for (step_no = 0; step_no < span && !hold_request; step_no++) begin
          @(posedge clk);
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom);
            2:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ((step_no % period) == 0);
          endcase
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int          phase_no, item_no, item_total;
    logic [15:0] half, limit;
    logic [7:0]  poll_ticks;
    logic        wide_sel;

    // Model state after reset: registers at their reset values, the
    // sequencer idle and every pin low.
    cfg_model = '{mwe_pkg::HALF_PERIOD_RESET, mwe_pkg::POLL_TICKS_RESET,
                  mwe_pkg::POLL_LIMIT_RESET, 1'b0};
    seq       = SEQ_IDLE;
    wait_left = '0;
    polls     = '0;
    bits_left = '0;
    cmd_bits  = '0;
    shift_in  = '0;
    wide      = 1'b0;
    {pin_req, pin_cs, pin_di, pin_clk} = 4'b0000;

    // The scripted part. Under the reset settings a start raises the
    // request, a second start while busy changes nothing, and with the
    // poll limit lowered mid-read the grant times out. Then both intervals
    // are set to zero, which must behave like one, and a zero poll limit
    // gives a single grant check. A read on the large part latches the
    // eight-bit address length even when the register is cleared during
    // the read.
    script = '{
      tick_row(1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, levels(0, 0, 0, 0, 0, 0, 0, 16'h0000)),
      tick_row(1'b1, 8'h00, 1'b0, 1'b0, 1'b1, levels(0, 0, 0, 1, 1, 0, 0, 16'h0000)),
      tick_row(1'b1, 8'hFF, 1'b0, 1'b1, 1'b1, levels(0, 0, 0, 1, 1, 0, 0, 16'h0000)),
      reg_row(mwe_pkg::REG_POLL_LIMIT, 16'd1),
      tick_row(1'b0, 8'h55, 1'b0, 1'b0, 1'b0, '0),
      tick_row(1'b1, 8'hAA, 1'b0, 1'b1, 1'b0, '0),
      tick_row(1'b0, 8'h0F, 1'b0, 1'b0, 1'b0, '0),
      tick_row(1'b1, 8'hF0, 1'b0, 1'b1, 1'b0, '0),
      tick_row(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, levels(0, 0, 0, 0, 0, 1, 1, 16'h0000)),
      reg_row(mwe_pkg::REG_HALF_PERIOD, 16'd0),
      reg_row(mwe_pkg::REG_POLL_TICKS, 16'hFF00),
      reg_row(mwe_pkg::REG_POLL_LIMIT, 16'd0),
      reg_row(mwe_pkg::REG_LARGE_PART, 16'hFFFF),
      tick_row(1'b1, 8'hA5, 1'b0, 1'b0, 1'b1, levels(0, 0, 0, 1, 1, 0, 0, 16'h0000)),
      tick_row(1'b0, 8'h00, 1'b0, 1'b1, 1'b1, levels(0, 0, 0, 0, 0, 1, 1, 16'h0000)),
      tick_row(1'b1, 8'hFF, 1'b1, 1'b0, 1'b1, levels(0, 0, 0, 1, 1, 0, 0, 16'h0000)),
      tick_row(1'b0, 8'h00, 1'b1, 1'b0, 1'b1, levels(0, 1, 1, 1, 1, 0, 0, 16'h0000)),
      reg_row(mwe_pkg::REG_LARGE_PART, 16'h0000),
      tick_row(1'b1, 8'h3C, 1'b1, 1'b1, 1'b0, '0),
      tick_row(1'b0, 8'hC3, 1'b0, 1'b0, 1'b0, '0),
      tick_row(1'b1, 8'h81, 1'b1, 1'b1, 1'b0, '0),
      tick_row(1'b0, 8'h7E, 1'b0, 1'b0, 1'b0, '0),
      tick_row(1'b1, 8'h18, 1'b1, 1'b1, 1'b0, '0),
      tick_row(1'b0, 8'hE7, 1'b0, 1'b1, 1'b0, '0)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_write) begin
        // Registers only change once the block has caught up.
        wait_for_results();
        write_register(script[i].reg_index, script[i].reg_value);
      end else begin
        send_tick(script[i].tick, script[i].typed, script[i].result);
      end
    end

    // Random phases. Each one drains the block, rewrites every register and
    // then runs a stretch of random ticks; a read in progress carries over
    // into the next setting. Most phases keep the serial clock fast so that
    // many reads complete, and the last one uses the slowest settings.
    for (phase_no = 0; phase_no < NUM_PHASES; phase_no++) begin
      item_total = PHASE_ITEMS;
      if (phase_no > 0) begin
        wait_for_results();
        half = 16'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
          0:       poll_ticks = 8'd0;
          1:       poll_ticks = 8'd255;
          default: poll_ticks = 8'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 5))
          0:       limit = 16'd0;
          1:       limit = 16'd65535;
          default: limit = 16'($urandom_range(1, 4));
        endcase
        wide_sel = 1'($urandom);
        if (phase_no == NUM_PHASES - 1) begin
          half       = 16'd65535;
          poll_ticks = 8'd1;
          limit      = 16'd65535;
          item_total = SLOW_ITEMS;
        end
        // Unused upper bits of the narrow registers carry random values.
        write_register(mwe_pkg::REG_HALF_PERIOD, half);
        write_register(mwe_pkg::REG_POLL_TICKS, {8'($urandom), poll_ticks});
        write_register(mwe_pkg::REG_POLL_LIMIT, limit);
        write_register(mwe_pkg::REG_LARGE_PART, {15'($urandom), wide_sel});
      end
      for (item_no = 0; item_no < item_total; item_no++) begin
        if (phase_no == HOLD_PHASE && item_no == 30) hold_request = 1'b1;
        send_tick(next_random_tick(), 1'b0, '0);
      end
    end

    wait_for_results();
    if (pending_levels.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_levels.size()));

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
